[rtl/core/afcs_pkg.sv]
// ----------------------------------------------------------------------------
// afcs_pkg
// Shared types and constants of the adaptive force control step.
// ----------------------------------------------------------------------------
`default_nettype none

package afcs_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned DEN_WIDTH       = 32;

   localparam logic [DEN_WIDTH-1:0] MM_PER_METER = DEN_WIDTH'(1000);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ORIGIN_HEIGHT = 3'd0,
      CSR_LAMBDA_GAIN   = 3'd1,
      CSR_ERROR_GAIN    = 3'd2,
      CSR_ADAPT_RATE    = 3'd3,
      CSR_BASE_FORCE    = 3'd4,
      CSR_GRAVITY_TERM  = 3'd5
   } afcs_csr_type;

   localparam logic signed [31:0] RST_ORIGIN_HEIGHT = 32'sd0;
   localparam logic [30:0]        RST_LAMBDA_GAIN   = 31'd655360;
   localparam logic [30:0]        RST_ERROR_GAIN    = 31'd393216;
   localparam logic [30:0]        RST_ADAPT_RATE    = 31'd131072;
   localparam logic signed [31:0] RST_BASE_FORCE    = 32'sd0;
   localparam logic signed [31:0] RST_GRAVITY_TERM  = 32'sd642908;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_EDGE,
      ST_POST_TOP,
      ST_POST_HEIGHT,
      ST_DIV_VEL,
      ST_MUL_HR,
      ST_MUL_S,
      ST_MUL_U1,
      ST_MUL_U2,
      ST_MUL_U3,
      ST_MUL_F1,
      ST_MUL_F2,
      ST_DONE
   } afcs_state_type;

endpackage

`default_nettype wire

[rtl/core/adaptive_force_control_step.sv]
// ----------------------------------------------------------------------------
// adaptive_force_control_step
// Sliding-surface adaptive force controller, one camera word in, one command
// word out, built around a bit-serial multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// One word is processed at a time. The edge division runs only when the edge
// was detected and the velocity division only when the time step is nonzero.
// The work is done by the restoring divider, which retires one quotient bit
// a cycle, and by the shift-and-add multiplier, which consumes one multiplier
// bit a cycle for each of the seven products. The next word is accepted while
// the previous result still waits.
`default_nettype none

module adaptive_force_control_step #(
   parameter int unsigned FRAC_BITS  = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_detected,
   input  wire logic signed [31:0] req_edge_depth_mm,
   input  wire logic [31:0]        req_sample_time,
   input  wire logic signed [31:0] req_ref_height,
   input  wire logic signed [31:0] req_ref_velocity,
   input  wire logic signed [31:0] req_ref_accel,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_force_cmd,
   output logic signed [31:0]      rsp_cur_height,
   output logic signed [31:0]      rsp_velocity,
   output logic signed [31:0]      rsp_sliding_error,
   output logic signed [31:0]      rsp_ref_term,
   output logic signed [31:0]      rsp_adapt_gain,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [afcs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int unsigned MAG = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
   localparam int unsigned SW  = MAG + 2;
   localparam int unsigned PW  = 2 * MAG + 2;
   localparam int unsigned NB  = MAG + FRAC_BITS;
   localparam int unsigned CW  = $clog2(NB + 2);
   localparam int unsigned QW  = DATA_WIDTH + 1;
   localparam int unsigned DW  = afcs_pkg::DEN_WIDTH;

   localparam logic signed [DATA_WIDTH-1:0] MAX_W = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MIN_W = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   function automatic logic signed [DATA_WIDTH-1:0] sat_sw(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = SW'(MAX_W);
      lo = SW'(MIN_W);
      if (v > hi) begin
         sat_sw = MAX_W;
      end else if (v < lo) begin
         sat_sw = MIN_W;
      end else begin
         sat_sw = v[DATA_WIDTH-1:0];
      end
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_mag(input logic neg,
                                                           input logic [PW-1:0] m);
      logic [PW-1:0]                 lim;
      logic signed [DATA_WIDTH-1:0] pos;
      lim = PW'(1) << (DATA_WIDTH - 1);
      pos = m[DATA_WIDTH-1:0];
      if (neg) begin
         sat_mag = (m >= lim) ? MIN_W : -pos;
      end else begin
         sat_mag = (m >= lim) ? MAX_W : pos;
      end
   endfunction

   function automatic logic [MAG-1:0] mag_of(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] n;
      n = -v;
      mag_of = v[SW-1] ? n[MAG-1:0] : v[MAG-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [DATA_WIDTH-1:0] v);
      logic signed [SW-1:0] e;
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      e  = SW'(v);
      hi = SW'(32'sh7FFF_FFFF);
      lo = SW'(-32'sh7FFF_FFFF - 32'sd1);
      if (e > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (e < lo) begin
         sat32 = -32'sh7FFF_FFFF - 32'sd1;
      end else begin
         sat32 = e[31:0];
      end
   endfunction

   afcs_pkg::afcs_state_type state_ff;
   afcs_pkg::afcs_state_type state_in;
   logic [CW-1:0]            cnt_ff;

   logic signed [31:0] origin_ff;
   logic [30:0]        lambda_ff;
   logic [30:0]        err_gain_ff;
   logic [30:0]        rate_ff;
   logic signed [31:0] base_ff;
   logic signed [31:0] grav_ff;

   logic signed [31:0]           edge_ff;
   logic [31:0]                  now_ff;
   logic signed [31:0]           rh_ff;
   logic signed [31:0]           rv_ff;
   logic signed [31:0]           ra_ff;

   logic signed [DATA_WIDTH-1:0] held_ff;
   logic signed [DATA_WIDTH-1:0] hn_ff;
   logic signed [DATA_WIDTH-1:0] hlast_ff;
   logic signed [DATA_WIDTH-1:0] vel_ff;
   logic signed [DATA_WIDTH-1:0] gain_ff;
   logic [31:0]                  last_ff;
   logic signed [32:0]           dt_ff;
   logic signed [DATA_WIDTH-1:0] hr_ff;
   logic signed [DATA_WIDTH-1:0] s_ff;
   logic signed [DATA_WIDTH-1:0] g_ff;
   logic signed [DATA_WIDTH-1:0] t_ff;
   logic signed [DATA_WIDTH-1:0] f_ff;

   logic [MAG-1:0] mcand_ff;
   logic [MAG:0]   mhi_ff;
   logic [MAG-1:0] mlo_ff;
   logic           mneg_ff;

   logic [NB-1:0]  dsr_ff;
   logic [DW-1:0]  ud_ff;
   logic [DW-1:0]  r_ff;
   logic [QW-1:0]  q_ff;
   logic           over_ff;
   logic           dneg_ff;

   logic                  rsp_valid_ff;
   logic signed [31:0]    out_force_ff;
   logic signed [31:0]    out_height_ff;
   logic signed [31:0]    out_vel_ff;
   logic signed [31:0]    out_s_ff;
   logic signed [31:0]    out_hr_ff;
   logic signed [31:0]    out_gain_ff;

   logic is_mul;
   logic is_div;
   logic mul_fin;
   logic div_fin;
   logic out_free;
   logic out_load;
   logic req_take;

   logic signed [SW-1:0]         ma;
   logic signed [SW-1:0]         mb;
   logic signed [SW-1:0]         dnum;
   logic signed [SW-1:0]         dden;
   logic                         dz;
   logic [MAG:0]                 madd;
   logic [2*MAG-1:0]             prod;
   logic [PW-1:0]                prod_rnd;
   logic signed [DATA_WIDTH-1:0] pr;
   logic [DW:0]                  rr;
   logic                         rge;
   logic [DW:0]                  rsub;
   logic                         rnd_bit;
   logic [DATA_WIDTH+1:0]        qf;
   logic [PW-1:0]                qmag;
   logic signed [DATA_WIDTH-1:0] dq;
   logic signed [DATA_WIDTH-1:0] top;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         afcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_detected ? afcs_pkg::ST_DIV_EDGE : afcs_pkg::ST_POST_TOP;
            end
         end
         afcs_pkg::ST_DIV_EDGE: begin
            if (div_fin) state_in = afcs_pkg::ST_POST_TOP;
         end
         afcs_pkg::ST_POST_TOP:    state_in = afcs_pkg::ST_POST_HEIGHT;
         afcs_pkg::ST_POST_HEIGHT: begin
            state_in = (dt_ff != 33'sd0) ? afcs_pkg::ST_DIV_VEL : afcs_pkg::ST_MUL_HR;
         end
         afcs_pkg::ST_DIV_VEL: begin
            if (div_fin) state_in = afcs_pkg::ST_MUL_HR;
         end
         afcs_pkg::ST_MUL_HR: begin
            if (mul_fin) state_in = afcs_pkg::ST_MUL_S;
         end
         afcs_pkg::ST_MUL_S: begin
            if (mul_fin) state_in = afcs_pkg::ST_MUL_U1;
         end
         afcs_pkg::ST_MUL_U1: begin
            if (mul_fin) state_in = afcs_pkg::ST_MUL_U2;
         end
         afcs_pkg::ST_MUL_U2: begin
            if (mul_fin) state_in = afcs_pkg::ST_MUL_U3;
         end
         afcs_pkg::ST_MUL_U3: begin
            if (mul_fin) state_in = afcs_pkg::ST_MUL_F1;
         end
         afcs_pkg::ST_MUL_F1: begin
            if (mul_fin) state_in = afcs_pkg::ST_MUL_F2;
         end
         afcs_pkg::ST_MUL_F2: begin
            if (mul_fin) state_in = afcs_pkg::ST_DONE;
         end
         afcs_pkg::ST_DONE: begin
            if (out_free) state_in = afcs_pkg::ST_IDLE;
         end
         default: state_in = afcs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      is_mul   = state_ff inside {afcs_pkg::ST_MUL_HR, afcs_pkg::ST_MUL_S,
                                  afcs_pkg::ST_MUL_U1, afcs_pkg::ST_MUL_U2,
                                  afcs_pkg::ST_MUL_U3, afcs_pkg::ST_MUL_F1,
                                  afcs_pkg::ST_MUL_F2};
      is_div   = state_ff inside {afcs_pkg::ST_DIV_EDGE, afcs_pkg::ST_DIV_VEL};
      mul_fin  = is_mul && (cnt_ff == CW'(MAG + 1));
      div_fin  = is_div && (cnt_ff == CW'(NB + 1));
      out_free = !rsp_valid_ff || !rsp_stall;
      out_load = (state_ff == afcs_pkg::ST_DONE) && out_free;
      req_stall = (state_ff != afcs_pkg::ST_IDLE);
      req_take  = req_valid && !req_stall;
      csr_ready = 1'b1;
   end

   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         afcs_pkg::ST_MUL_HR: begin
            ma = SW'({1'b0, lambda_ff});
            mb = SW'(vel_ff);
         end
         afcs_pkg::ST_MUL_S: begin
            ma = SW'({1'b0, lambda_ff});
            mb = SW'(sat_sw(SW'(hn_ff) - SW'(rh_ff)));
         end
         afcs_pkg::ST_MUL_U1: begin
            ma = SW'({1'b0, rate_ff});
            mb = SW'(s_ff);
         end
         afcs_pkg::ST_MUL_U2: begin
            ma = SW'(t_ff);
            mb = SW'(g_ff);
         end
         afcs_pkg::ST_MUL_U3: begin
            ma = SW'(t_ff);
            mb = SW'(dt_ff);
         end
         afcs_pkg::ST_MUL_F1: begin
            ma = SW'(gain_ff);
            mb = SW'(g_ff);
         end
         afcs_pkg::ST_MUL_F2: begin
            ma = SW'({1'b0, err_gain_ff});
            mb = SW'(s_ff);
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   always_comb begin
      if (state_ff == afcs_pkg::ST_DIV_EDGE) begin
         dnum = -SW'(edge_ff);
         dden = SW'({1'b0, afcs_pkg::MM_PER_METER});
         dz   = 1'b0;
      end else begin
         dnum = SW'(sat_sw(SW'(hn_ff) - SW'(hlast_ff)));
         dden = SW'(dt_ff);
         dz   = 1'b1;
      end
   end

   always_comb begin
      madd     = mhi_ff + (mlo_ff[0] ? {1'b0, mcand_ff} : {(MAG+1){1'b0}});
      prod     = {mhi_ff[MAG-1:0], mlo_ff};
      prod_rnd = (PW'(prod) + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      pr       = sat_mag(mneg_ff, prod_rnd);

      rr      = {r_ff, dsr_ff[NB-1]};
      rge     = rr >= {1'b0, ud_ff};
      rsub    = rr - {1'b0, ud_ff};
      rnd_bit = {r_ff, 1'b0} >= {1'b0, ud_ff};
      qf      = (DATA_WIDTH+2)'(q_ff) + (DATA_WIDTH+2)'(rnd_bit);
      qmag    = over_ff ? {PW{1'b1}} : PW'(qf);
      dq      = sat_mag(dneg_ff, qmag);

      top = sat_sw(SW'(hn_ff) + SW'(origin_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afcs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         origin_ff    <= afcs_pkg::RST_ORIGIN_HEIGHT;
         lambda_ff    <= afcs_pkg::RST_LAMBDA_GAIN;
         err_gain_ff  <= afcs_pkg::RST_ERROR_GAIN;
         rate_ff      <= afcs_pkg::RST_ADAPT_RATE;
         base_ff      <= afcs_pkg::RST_BASE_FORCE;
         grav_ff      <= afcs_pkg::RST_GRAVITY_TERM;
         held_ff      <= '0;
         hn_ff        <= '0;
         last_ff      <= '0;
         vel_ff       <= '0;
         gain_ff      <= '0;
      end else begin
         state_ff <= state_in;

         if (is_mul || is_div) begin
            cnt_ff <= (mul_fin || div_fin) ? '0 : cnt_ff + CW'(1);
         end else begin
            cnt_ff <= '0;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               afcs_pkg::CSR_ORIGIN_HEIGHT: origin_ff   <= csr_wdata;
               afcs_pkg::CSR_LAMBDA_GAIN:   lambda_ff   <= csr_wdata[30:0];
               afcs_pkg::CSR_ERROR_GAIN:    err_gain_ff <= csr_wdata[30:0];
               afcs_pkg::CSR_ADAPT_RATE:    rate_ff     <= csr_wdata[30:0];
               afcs_pkg::CSR_BASE_FORCE:    base_ff     <= csr_wdata;
               afcs_pkg::CSR_GRAVITY_TERM:  grav_ff     <= csr_wdata;
               default: ;
            endcase
         end

         case (state_ff)
            afcs_pkg::ST_DIV_EDGE: begin
               if (div_fin) held_ff <= dq;
            end
            afcs_pkg::ST_POST_TOP: begin
               if (held_ff > top) held_ff <= top;
               last_ff <= now_ff;
            end
            afcs_pkg::ST_POST_HEIGHT: begin
               hn_ff <= sat_sw(SW'(held_ff) - SW'(origin_ff));
            end
            afcs_pkg::ST_DIV_VEL: begin
               if (div_fin) vel_ff <= dq;
            end
            afcs_pkg::ST_MUL_U3: begin
               if (mul_fin) gain_ff <= sat_sw(SW'(gain_ff) - SW'(pr));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         edge_ff <= req_edge_depth_mm;
         now_ff  <= req_sample_time;
         rh_ff   <= req_ref_height;
         rv_ff   <= req_ref_velocity;
         ra_ff   <= req_ref_accel;
      end

      if (state_ff == afcs_pkg::ST_POST_TOP) begin
         dt_ff <= $signed({1'b0, now_ff}) - $signed({1'b0, last_ff});
      end
      if (state_ff == afcs_pkg::ST_POST_HEIGHT) begin
         hlast_ff <= hn_ff;
      end

      if (is_div) begin
         if (cnt_ff == '0) begin
            dsr_ff  <= dz ? {mag_of(dnum), {FRAC_BITS{1'b0}}}
                          : {{FRAC_BITS{1'b0}}, mag_of(dnum)};
            ud_ff   <= DW'(mag_of(dden));
            r_ff    <= '0;
            q_ff    <= '0;
            over_ff <= 1'b0;
            dneg_ff <= dnum[SW-1] ^ dden[SW-1];
         end else if (!div_fin) begin
            dsr_ff  <= {dsr_ff[NB-2:0], 1'b0};
            r_ff    <= rge ? rsub[DW-1:0] : rr[DW-1:0];
            q_ff    <= {q_ff[QW-2:0], rge};
            over_ff <= over_ff | q_ff[QW-1];
         end
      end

      if (is_mul) begin
         if (cnt_ff == '0) begin
            mcand_ff <= mag_of(ma);
            mlo_ff   <= mag_of(mb);
            mhi_ff   <= '0;
            mneg_ff  <= ma[SW-1] ^ mb[SW-1];
         end else if (!mul_fin) begin
            mhi_ff <= {1'b0, madd[MAG:1]};
            mlo_ff <= {madd[0], mlo_ff[MAG-1:1]};
         end
      end

      if (mul_fin) begin
         case (state_ff)
            afcs_pkg::ST_MUL_HR: hr_ff <= sat_sw(SW'(ra_ff) - SW'(pr));
            afcs_pkg::ST_MUL_S: begin
               s_ff <= sat_sw(SW'(sat_sw(SW'(vel_ff) - SW'(rv_ff))) + SW'(pr));
               g_ff <= sat_sw(SW'(hr_ff) + SW'(grav_ff));
            end
            afcs_pkg::ST_MUL_U1: t_ff <= pr;
            afcs_pkg::ST_MUL_U2: t_ff <= pr;
            afcs_pkg::ST_MUL_F1: f_ff <= sat_sw(SW'(base_ff) + SW'(pr));
            afcs_pkg::ST_MUL_F2: f_ff <= sat_sw(SW'(f_ff) - SW'(pr));
            default: ;
         endcase
      end

      if (out_load) begin
         out_force_ff  <= sat32(f_ff);
         out_height_ff <= sat32(hn_ff);
         out_vel_ff    <= sat32(vel_ff);
         out_s_ff      <= sat32(s_ff);
         out_hr_ff     <= sat32(hr_ff);
         out_gain_ff   <= sat32(gain_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_force_cmd     = out_force_ff;
   assign rsp_cur_height    = out_height_ff;
   assign rsp_velocity      = out_vel_ff;
   assign rsp_sliding_error = out_s_ff;
   assign rsp_ref_term      = out_hr_ff;
   assign rsp_adapt_gain    = out_gain_ff;

endmodule

`default_nettype wire

[verif/adaptive_force_control_step_tb.sv]
// ----------------------------------------------------------------------------
// adaptive_force_control_step_tb
// Self-checking bench for the adaptive force controller. Camera words go in
// from a queue under random gaps, command words are checked field by field
// against an in-bench fixed-point controller model, and the control registers
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_force_control_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam longint MAG_LIMIT = 64'sh4000000000000000;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam int DONE_WAIT = 400;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic        detected;
      logic [31:0] edge_depth_mm;
      logic [31:0] sample_time;
      logic [31:0] ref_height;
      logic [31:0] ref_velocity;
      logic [31:0] ref_accel;
   } camera_word_type;

   typedef struct packed {
      logic [31:0] force_cmd;
      logic [31:0] cur_height;
      logic [31:0] velocity;
      logic [31:0] sliding_error;
      logic [31:0] ref_term;
      logic [31:0] adapt_gain;
   } command_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic req_detected = 1'b0;
   logic signed [31:0] req_edge_depth_mm = '0;
   logic [31:0] req_sample_time = '0;
   logic signed [31:0] req_ref_height = '0;
   logic signed [31:0] req_ref_velocity = '0;
   logic signed [31:0] req_ref_accel = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_force_cmd;
   logic signed [31:0] rsp_cur_height;
   logic signed [31:0] rsp_velocity;
   logic signed [31:0] rsp_sliding_error;
   logic signed [31:0] rsp_ref_term;
   logic signed [31:0] rsp_adapt_gain;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [afcs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   camera_word_type pending_words[$];
   command_word_type expected_commands[$];
   int send_idle_pct = 20;
   int recv_idle_pct = 78;
   bit hold_receiver = 1'b0;
   int hold_count = 0;
   int fail_count = 0;
   int idle_cycles = 0;

   // Controller model state and registers.
   longint m_origin, m_lambda, m_err_gain, m_rate, m_base, m_gravity;
   longint m_held, m_height, m_vel, m_gain;
   longint unsigned m_last_time;

   always #5 clock = ~clock;

   adaptive_force_control_step DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_detected(req_detected), .req_edge_depth_mm(req_edge_depth_mm),
      .req_sample_time(req_sample_time), .req_ref_height(req_ref_height),
      .req_ref_velocity(req_ref_velocity), .req_ref_accel(req_ref_accel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_force_cmd(rsp_force_cmd), .rsp_cur_height(rsp_cur_height),
      .rsp_velocity(rsp_velocity), .rsp_sliding_error(rsp_sliding_error),
      .rsp_ref_term(rsp_ref_term), .rsp_adapt_gain(rsp_adapt_gain),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic longint clamp32(longint v);
      return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   // Fixed-point product, rounded half away from zero, then saturated.
   function automatic longint fx_mul(longint a, longint b);
      logic [127:0] p;
      logic [127:0] r;
      longint unsigned q;
      bit neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      r = (p + (128'd1 << (FRAC - 1))) >> FRAC;
      q = (r >= 128'(MAG_LIMIT)) ? MAG_LIMIT : r[63:0];
      return clamp32(neg ? -longint'(q) : longint'(q));
   endfunction

   // (num << shift) / den, rounded half away from zero, then saturated.
   function automatic longint fx_div(longint num, int shift, longint den);
      logic [127:0] n;
      logic [127:0] d;
      logic [127:0] q;
      logic [127:0] r;
      longint unsigned qm;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = {64'd0, magnitude(num)} << shift;
      d = {64'd0, magnitude(den)};
      q = n / d;
      r = n % d;
      if (q >= 128'(MAG_LIMIT)) qm = MAG_LIMIT;
      else qm = q[63:0] + ((2 * r >= d) ? 64'd1 : 64'd0);
      return clamp32(neg ? -longint'(qm) : longint'(qm));
   endfunction

   task automatic model_reset();
      m_origin = afcs_pkg::RST_ORIGIN_HEIGHT;
      m_lambda = afcs_pkg::RST_LAMBDA_GAIN;
      m_err_gain = afcs_pkg::RST_ERROR_GAIN;
      m_rate = afcs_pkg::RST_ADAPT_RATE;
      m_base = afcs_pkg::RST_BASE_FORCE;
      m_gravity = afcs_pkg::RST_GRAVITY_TERM;
      m_held = 0;
      m_height = 0;
      m_vel = 0;
      m_gain = 0;
      m_last_time = 0;
   endtask

   task automatic model_write_register(afcs_pkg::afcs_csr_type idx, logic [31:0] value);
      case (idx)
         afcs_pkg::CSR_ORIGIN_HEIGHT: m_origin = longint'(signed'(value));
         afcs_pkg::CSR_LAMBDA_GAIN: m_lambda = value[30:0];
         afcs_pkg::CSR_ERROR_GAIN: m_err_gain = value[30:0];
         afcs_pkg::CSR_ADAPT_RATE: m_rate = value[30:0];
         afcs_pkg::CSR_BASE_FORCE: m_base = longint'(signed'(value));
         afcs_pkg::CSR_GRAVITY_TERM: m_gravity = longint'(signed'(value));
         default: ;
      endcase
   endtask

   function automatic command_word_type predict_command(camera_word_type w);
      command_word_type c;
      longint top, dt, h_last, hr, s, g, upd, f;
      if (w.detected) m_held = fx_div(-longint'(signed'(w.edge_depth_mm)), 0, 1000);
      top = clamp32(m_height + m_origin);
      if (m_held > top) m_held = top;
      dt = longint'(w.sample_time) - longint'(m_last_time);
      m_last_time = w.sample_time;
      h_last = m_height;
      m_height = clamp32(m_held - m_origin);
      if (dt != 0) m_vel = fx_div(clamp32(m_height - h_last), FRAC, dt);
      hr = clamp32(longint'(signed'(w.ref_accel)) - fx_mul(m_lambda, m_vel));
      s = clamp32(clamp32(m_vel - longint'(signed'(w.ref_velocity)))
                  + fx_mul(m_lambda, clamp32(m_height - longint'(signed'(w.ref_height)))));
      g = clamp32(hr + m_gravity);
      upd = fx_mul(fx_mul(fx_mul(m_rate, s), g), dt);
      m_gain = clamp32(m_gain - upd);
      f = clamp32(m_base + fx_mul(m_gain, g));
      f = clamp32(f - fx_mul(m_err_gain, s));
      c.force_cmd = f[31:0];
      c.cur_height = m_height[31:0];
      c.velocity = m_vel[31:0];
      c.sliding_error = s[31:0];
      c.ref_term = hr[31:0];
      c.adapt_gain = m_gain[31:0];
      return c;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_commands.push_back(predict_command({req_detected,
            req_edge_depth_mm, req_sample_time, req_ref_height, req_ref_velocity,
            req_ref_accel}));
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            camera_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_detected <= w.detected;
            req_edge_depth_mm <= w.edge_depth_mm;
            req_sample_time <= w.sample_time;
            req_ref_height <= w.ref_height;
            req_ref_velocity <= w.ref_velocity;
            req_ref_accel <= w.ref_accel;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor and receiver stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         command_word_type got;
         command_word_type want;
         got = {rsp_force_cmd, rsp_cur_height, rsp_velocity, rsp_sliding_error,
                rsp_ref_term, rsp_adapt_gain};
         if (expected_commands.size() == 0) begin
            $display("%0t: unexpected command word %h", $time, got);
            fail_count++;
         end else begin
            want = expected_commands.pop_front();
            if (got.force_cmd !== want.force_cmd)
               $display("%0t: force_cmd expected %h got %h", $time, want.force_cmd, got.force_cmd);
            if (got.cur_height !== want.cur_height)
               $display("%0t: cur_height expected %h got %h", $time, want.cur_height,
                        got.cur_height);
            if (got.velocity !== want.velocity)
               $display("%0t: velocity expected %h got %h", $time, want.velocity, got.velocity);
            if (got.sliding_error !== want.sliding_error)
               $display("%0t: sliding_error expected %h got %h", $time, want.sliding_error,
                        got.sliding_error);
            if (got.ref_term !== want.ref_term)
               $display("%0t: ref_term expected %h got %h", $time, want.ref_term, got.ref_term);
            if (got.adapt_gain !== want.adapt_gain)
               $display("%0t: adapt_gain expected %h got %h", $time, want.adapt_gain,
                        got.adapt_gain);
            if (got !== want) fail_count++;
         end
      end
      if (hold_receiver && hold_count < HOLD_CYCLES)
         hold_count <= hold_count + 1;
      else if (!hold_receiver)
         hold_count <= 0;
      rsp_stall <= (hold_receiver && hold_count < HOLD_CYCLES) ||
                   ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_commands.size() > 0)
         @(posedge clock);
      repeat (DONE_WAIT) @(posedge clock);
   endtask

   task automatic write_register(afcs_pkg::afcs_csr_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_write_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_field();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   // Mostly realistic sequence: non-decreasing time and bounded depths; one word in ten is fully random.
   task automatic queue_words(int count, ref logic [31:0] clock_time);
      camera_word_type w;
      repeat (count) begin
         if ($urandom_range(9) == 0) begin
            w = {1'($urandom), random_field(), 32'($urandom), random_field(),
                 random_field(), random_field()};
         end else begin
            clock_time += ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(4000));
            w.detected = ($urandom_range(5) != 0);
            w.edge_depth_mm = 32'($signed($urandom_range(20000000)) - 2000000);
            w.sample_time = clock_time;
            w.ref_height = 32'($signed($urandom_range(400000)) - 200000);
            w.ref_velocity = 32'($signed($urandom_range(200000)) - 100000);
            w.ref_accel = 32'($signed($urandom_range(2000000)) - 1000000);
         end
         pending_words.push_back(w);
      end
   endtask

   task automatic randomize_registers();
      write_register(afcs_pkg::CSR_ORIGIN_HEIGHT,
                     32'($signed($urandom_range(400000)) - 200000));
      write_register(afcs_pkg::CSR_LAMBDA_GAIN, $urandom_range(1000000));
      write_register(afcs_pkg::CSR_ERROR_GAIN, $urandom_range(1000000));
      write_register(afcs_pkg::CSR_ADAPT_RATE, $urandom_range(300000));
      write_register(afcs_pkg::CSR_BASE_FORCE,
                     32'($signed($urandom_range(400000)) - 200000));
      write_register(afcs_pkg::CSR_GRAVITY_TERM,
                     32'($signed($urandom_range(1300000)) - 650000));
   endtask

   initial begin
      logic [31:0] clock_time;
      clock_time = 0;
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at default settings.
      pending_words.push_back({1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      pending_words.push_back({1'b1, 32'h00010000, 32'h00000100, 32'h0, 32'h0, 32'h0});
      pending_words.push_back({1'b1, 32'hfff00000, 32'h00000200, 32'h0, 32'h0, 32'h0});
      pending_words.push_back({1'b0, 32'h7fffffff, 32'h00000200, 32'h0, 32'h0, 32'h0});
      pending_words.push_back({1'b1, 32'h7fffffff, 32'h00000100, 32'h7fffffff,
                               32'h80000000, 32'h7fffffff});
      pending_words.push_back({1'b1, 32'h80000000, 32'hffffffff, 32'h80000000,
                               32'h7fffffff, 32'h80000000});
      pending_words.push_back({1'b1, 32'h00001000, 32'h00000000, 32'h0, 32'h0, 32'h0});
      pending_words.push_back({1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                               32'hffffffff, 32'hffffffff});
      pending_words.push_back({1'b0, 32'h0, 32'h80000000, 32'h12345678,
                               32'h9abcdef0, 32'h0f0f0f0f});
      wait_drained();

      // Extreme register settings.
      write_register(afcs_pkg::CSR_ORIGIN_HEIGHT, 32'h7fffffff);
      write_register(afcs_pkg::CSR_LAMBDA_GAIN, 32'h7fffffff);
      write_register(afcs_pkg::CSR_ERROR_GAIN, 32'h7fffffff);
      write_register(afcs_pkg::CSR_ADAPT_RATE, 32'h7fffffff);
      write_register(afcs_pkg::CSR_BASE_FORCE, 32'h80000000);
      write_register(afcs_pkg::CSR_GRAVITY_TERM, 32'h7fffffff);
      clock_time = 32'h00010000;
      queue_words(12, clock_time);
      wait_drained();
      write_register(afcs_pkg::CSR_ORIGIN_HEIGHT, 32'h80000000);
      write_register(afcs_pkg::CSR_LAMBDA_GAIN, 32'h0);
      write_register(afcs_pkg::CSR_ERROR_GAIN, 32'h0);
      write_register(afcs_pkg::CSR_ADAPT_RATE, 32'h0);
      write_register(afcs_pkg::CSR_BASE_FORCE, 32'h7fffffff);
      write_register(afcs_pkg::CSR_GRAVITY_TERM, 32'h80000000);
      queue_words(12, clock_time);
      wait_drained();

      // Random phases with changing idle patterns.
      send_idle_pct = 20;
      recv_idle_pct = 78;
      randomize_registers();
      queue_words(400, clock_time);
      wait_drained();

      // Long receiver hold while the sender keeps offering.
      hold_receiver = 1'b1;
      queue_words(20, clock_time);
      wait (hold_count >= HOLD_CYCLES);
      hold_receiver = 1'b0;
      wait_drained();

      send_idle_pct = 78;
      recv_idle_pct = 20;
      randomize_registers();
      queue_words(400, clock_time);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(afcs_pkg::CSR_LAMBDA_GAIN, afcs_pkg::RST_LAMBDA_GAIN);
      write_register(afcs_pkg::CSR_ERROR_GAIN, afcs_pkg::RST_ERROR_GAIN);
      write_register(afcs_pkg::CSR_ADAPT_RATE, afcs_pkg::RST_ADAPT_RATE);
      queue_words(400, clock_time);
      wait_drained();

      if (fail_count == 0 && expected_commands.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

`default_nettype wire
